// ===== hw/rtl/fmtsp_pkg.sv =====
package fmtsp_pkg;

    localparam int COUNT_BITS_DEFAULT = 31;
    localparam int FIELD_W            = 31;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_J     = 8'h6A;
    localparam logic [7:0] CH_Z     = 8'h7A;
    localparam logic [7:0] CH_T     = 8'h74;
    localparam logic [7:0] CH_BIG_L = 8'h4C;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_L     = 8'h6C;

    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_J    = 3'd1;
    localparam logic [2:0] LEN_Z    = 3'd2;
    localparam logic [2:0] LEN_T    = 3'd3;
    localparam logic [2:0] LEN_BIG_L = 3'd4;
    localparam logic [2:0] LEN_H    = 3'd5;
    localparam logic [2:0] LEN_L    = 3'd6;

    localparam logic [1:0] LEN2_NONE = 2'd0;
    localparam logic [1:0] LEN2_L    = 2'd1;
    localparam logic [1:0] LEN2_H    = 2'd2;

    typedef enum logic [7:0] {
        PH_IDLE        = 8'b0000_0001,
        PH_FLAGS       = 8'b0000_0010,
        PH_WIDTH       = 8'b0000_0100,
        PH_AFTER_WSTAR = 8'b0000_1000,
        PH_PREC        = 8'b0001_0000,
        PH_AFTER_PSTAR = 8'b0010_0000,
        PH_LEN1        = 8'b0100_0000,
        PH_CONV        = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic hash;
        logic zero;
        logic space;
        logic plus;
        logic minus;
    } flags_t;

    function automatic logic [2:0] length_code(input logic [7:0] b);
        logic [2:0] code;
        case (b)
            CH_J:     code = LEN_J;
            CH_Z:     code = LEN_Z;
            CH_T:     code = LEN_T;
            CH_BIG_L: code = LEN_BIG_L;
            CH_H:     code = LEN_H;
            CH_L:     code = LEN_L;
            default:  code = LEN_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== hw/rtl/format_specifier_parser_core.sv =====
// Channel | Handshake                   | Payload
// item    | item_valid / item_stall     | byte_in, start_req, star_value
// result  | result_valid / result_stall | flags, field_width, has_precision, precision,
//         |                             | length_first, length_second, conversion_byte
//
// One item is taken per cycle while item_stall is low; a result is registered when the item
// that ends it leaves the input register and the result register can take it.
// A single parse step lies between the input and result registers.
// Reset returns the parser to idle with all parsed fields cleared and both registers empty.
// A held result stalls the input only when the waiting item would produce another result.
module format_specifier_parser_core #(
    parameter int COUNT_BITS = fmtsp_pkg::COUNT_BITS_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic [7:0]                      byte_in,
    input  logic                            start_req,
    input  logic signed [31:0]              star_value,
    output logic                            result_valid,
    input  logic                            result_stall,
    output logic                            left_justify,
    output logic                            force_sign,
    output logic                            space_sign,
    output logic                            zero_pad,
    output logic                            alt_form,
    output logic [fmtsp_pkg::FIELD_W-1:0]   field_width,
    output logic                            has_precision,
    output logic [fmtsp_pkg::FIELD_W-1:0]   precision,
    output logic [2:0]                      length_first,
    output logic [1:0]                      length_second,
    output logic [7:0]                      conversion_byte
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic                     ir_valid_reg, ir_valid_next;
    logic [7:0]               ir_byte_reg;
    logic                     ir_start_reg;
    logic [31:0]              ir_star_reg;

    fmtsp_pkg::phase_t        phase_reg, phase_next;
    fmtsp_pkg::flags_t        flags_reg, flags_next;
    logic [COUNT_BITS-1:0]    width_reg, width_next;
    logic                     dot_reg, dot_next;
    logic [COUNT_BITS-1:0]    prec_reg, prec_next;
    logic [2:0]               len1_reg, len1_next;
    logic [1:0]               len2_reg, len2_next;

    logic                     res_valid_reg, res_valid_next;
    fmtsp_pkg::flags_t        res_flags_reg;
    logic [COUNT_BITS-1:0]    res_width_reg;
    logic                     res_dot_reg;
    logic [COUNT_BITS-1:0]    res_prec_reg;
    logic [2:0]               res_len1_reg;
    logic [1:0]               res_len2_reg;
    logic [7:0]               res_byte_reg;

    logic                     emit;
    logic                     advance;
    logic                     accept;

    function automatic logic [COUNT_BITS-1:0] add_digit(
        input logic [COUNT_BITS-1:0] acc,
        input logic [7:0]            b
    );
        logic [COUNT_BITS+3:0] ext;
        logic [COUNT_BITS+3:0] sum;
        logic [7:0]            d;
        ext = {4'b0000, acc};
        d   = b - fmtsp_pkg::CH_ZERO;
        sum = (ext << 3) + (ext << 1) + (COUNT_BITS+4)'(d[3:0]);
        return (sum > {4'b0000, CNT_MAX}) ? CNT_MAX : sum[COUNT_BITS-1:0];
    endfunction

    function automatic logic [COUNT_BITS-1:0] star_mag(input logic [31:0] raw);
        logic [31:0] mag;
        mag = raw[31] ? (~raw + 32'd1) : raw;
        return (mag > 32'(CNT_MAX)) ? CNT_MAX : mag[COUNT_BITS-1:0];
    endfunction

    always_comb
    begin
        fmtsp_pkg::phase_t ph;
        logic              is_digit;
        logic              in_flags;
        logic              in_width;
        logic              in_dot;
        logic              in_prec;
        logic [2:0]        lc;

        phase_next = phase_reg;
        flags_next = flags_reg;
        width_next = width_reg;
        dot_next   = dot_reg;
        prec_next  = prec_reg;
        len1_next  = len1_reg;
        len2_next  = len2_reg;
        emit       = 1'b0;

        if (ir_start_reg)
        begin
            flags_next = '0;
            width_next = '0;
            dot_next   = 1'b0;
            prec_next  = '0;
            len1_next  = fmtsp_pkg::LEN_NONE;
            len2_next  = fmtsp_pkg::LEN2_NONE;
            ph         = fmtsp_pkg::PH_FLAGS;
        end
        else
        begin
            ph = phase_reg;
        end
        phase_next = ph;

        is_digit = (ir_byte_reg >= fmtsp_pkg::CH_ZERO) && (ir_byte_reg <= fmtsp_pkg::CH_NINE);
        in_flags = (ph == fmtsp_pkg::PH_FLAGS);
        in_width = in_flags || (ph == fmtsp_pkg::PH_WIDTH);
        in_dot   = in_width || (ph == fmtsp_pkg::PH_AFTER_WSTAR);
        in_prec  = (ph == fmtsp_pkg::PH_PREC);
        lc       = fmtsp_pkg::length_code(ir_byte_reg);

        case (ph)
            fmtsp_pkg::PH_IDLE:
            begin
                phase_next = fmtsp_pkg::PH_IDLE;
            end
            fmtsp_pkg::PH_LEN1:
            begin
                if (ir_byte_reg == fmtsp_pkg::CH_L)
                begin
                    len2_next  = fmtsp_pkg::LEN2_L;
                    phase_next = fmtsp_pkg::PH_CONV;
                end
                else if (ir_byte_reg == fmtsp_pkg::CH_H)
                begin
                    len2_next  = fmtsp_pkg::LEN2_H;
                    phase_next = fmtsp_pkg::PH_CONV;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = fmtsp_pkg::PH_IDLE;
                end
            end
            fmtsp_pkg::PH_CONV:
            begin
                emit       = 1'b1;
                phase_next = fmtsp_pkg::PH_IDLE;
            end
            default:
            begin
                if (in_flags && ir_byte_reg == fmtsp_pkg::CH_MINUS)
                begin
                    flags_next.minus = 1'b1;
                end
                else if (in_flags && ir_byte_reg == fmtsp_pkg::CH_PLUS)
                begin
                    flags_next.plus = 1'b1;
                end
                else if (in_flags && ir_byte_reg == fmtsp_pkg::CH_SPACE)
                begin
                    flags_next.space = 1'b1;
                end
                else if (in_flags && ir_byte_reg == fmtsp_pkg::CH_ZERO)
                begin
                    flags_next.zero = 1'b1;
                end
                else if (in_flags && ir_byte_reg == fmtsp_pkg::CH_HASH)
                begin
                    flags_next.hash = 1'b1;
                end
                else if (in_width && is_digit)
                begin
                    width_next = add_digit(width_next, ir_byte_reg);
                    phase_next = fmtsp_pkg::PH_WIDTH;
                end
                else if (in_width && ir_byte_reg == fmtsp_pkg::CH_STAR)
                begin
                    width_next = star_mag(ir_star_reg);
                    if (ir_star_reg[31])
                    begin
                        flags_next.minus = 1'b1;
                    end
                    phase_next = fmtsp_pkg::PH_AFTER_WSTAR;
                end
                else if (in_dot && ir_byte_reg == fmtsp_pkg::CH_DOT)
                begin
                    dot_next   = 1'b1;
                    phase_next = fmtsp_pkg::PH_PREC;
                end
                else if (in_prec && is_digit)
                begin
                    prec_next = add_digit(prec_next, ir_byte_reg);
                end
                else if (in_prec && ir_byte_reg == fmtsp_pkg::CH_STAR)
                begin
                    prec_next = star_mag(ir_star_reg);
                    if (ir_star_reg[31])
                    begin
                        flags_next.minus = 1'b1;
                    end
                    phase_next = fmtsp_pkg::PH_AFTER_PSTAR;
                end
                else if (lc != fmtsp_pkg::LEN_NONE)
                begin
                    len1_next  = lc;
                    phase_next = fmtsp_pkg::PH_LEN1;
                end
                else
                begin
                    emit       = 1'b1;
                    phase_next = fmtsp_pkg::PH_IDLE;
                end
            end
        endcase
    end

    assign advance    = ir_valid_reg && (!emit || !res_valid_reg || !result_stall);
    assign item_stall = ir_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    always_comb
    begin
        ir_valid_next = ir_valid_reg;
        if (accept)
        begin
            ir_valid_next = 1'b1;
        end
        else if (advance)
        begin
            ir_valid_next = 1'b0;
        end

        res_valid_next = res_valid_reg;
        if (advance && emit)
        begin
            res_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            phase_reg     <= fmtsp_pkg::PH_IDLE;
            flags_reg     <= '0;
            width_reg     <= '0;
            dot_reg       <= 1'b0;
            prec_reg      <= '0;
            len1_reg      <= fmtsp_pkg::LEN_NONE;
            len2_reg      <= fmtsp_pkg::LEN2_NONE;
        end
        else
        begin
            ir_valid_reg  <= ir_valid_next;
            res_valid_reg <= res_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                flags_reg <= flags_next;
                width_reg <= width_next;
                dot_reg   <= dot_next;
                prec_reg  <= prec_next;
                len1_reg  <= len1_next;
                len2_reg  <= len2_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ir_byte_reg  <= byte_in;
            ir_start_reg <= start_req;
            ir_star_reg  <= star_value;
        end
        if (advance && emit)
        begin
            res_flags_reg <= flags_next;
            res_width_reg <= width_next;
            res_dot_reg   <= dot_next;
            res_prec_reg  <= prec_next;
            res_len1_reg  <= len1_next;
            res_len2_reg  <= len2_next;
            res_byte_reg  <= ir_byte_reg;
        end
    end

    assign result_valid    = res_valid_reg;
    assign left_justify    = res_flags_reg.minus;
    assign force_sign      = res_flags_reg.plus;
    assign space_sign      = res_flags_reg.space;
    assign zero_pad        = res_flags_reg.zero;
    assign alt_form        = res_flags_reg.hash;
    assign field_width     = fmtsp_pkg::FIELD_W'(res_width_reg);
    assign has_precision   = res_dot_reg;
    assign precision       = fmtsp_pkg::FIELD_W'(res_prec_reg);
    assign length_first    = res_len1_reg;
    assign length_second   = res_len2_reg;
    assign conversion_byte = res_byte_reg;

endmodule
